/* src/qwt_pkg.sv */
// Shared types and constants of the quoted word tokenizer.
package qwt_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_EOI  = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam int LEN_W = 11;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       ch;
        logic [LEN_W-1:0] len;
        logic             last;
    } result_t;

    // One queue entry carries every result that one input beat causes.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

/* src/qwt_front.sv */
// Front end: accepts input beats, runs the scanner state and builds result entries.
module qwt_front #(
    parameter int MAX_WORD = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    input  logic              q_full,
    output logic              push,
    output qwt_pkg::entry_t   push_entry
);

    localparam int CW = $clog2(MAX_WORD);
    localparam int LW = qwt_pkg::LEN_W;

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_STR   = 3'd1;
    localparam logic [2:0] M_WORD  = 3'd2;
    localparam logic [2:0] M_CMT   = 3'd3;
    localparam logic [2:0] M_SLASH = 3'd4;
    localparam logic [2:0] M_CSTAR = 3'd5;

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WORD - 1);
    localparam logic [CW-1:0] COUNT_ONE = CW'(1);
    localparam logic [CW-1:0] COUNT_TWO = CW'(2);

    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;

    logic          fire;
    logic          is_delim;
    logic          count_full;
    logic          one_full;
    logic [CW-1:0] count_inc;
    logic [CW+LW-1:0] ext_cur, ext_inc;
    logic [LW-1:0] len_cur, len_inc;
    qwt_pkg::entry_t ent;

    assign in_ready   = !q_full;
    assign fire       = in_valid && in_ready;
    assign is_delim   = (in_byte == qwt_pkg::CH_SPACE) || (in_byte == qwt_pkg::CH_TAB)
                     || (in_byte == qwt_pkg::CH_NL) || (in_byte == qwt_pkg::CH_COMMA);
    assign count_full = (count_reg == COUNT_MAX);
    assign one_full   = (COUNT_ONE == COUNT_MAX);
    assign count_inc  = count_reg + COUNT_ONE;
    // Lengths leave the block masked to eleven bits whatever the counter width.
    assign ext_cur    = {{LW{1'b0}}, count_reg};
    assign ext_inc    = {{LW{1'b0}}, count_inc};
    assign len_cur    = ext_cur[LW-1:0];
    assign len_inc    = ext_inc[LW-1:0];

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        push       = 1'b0;
        ent        = '0;
        if (fire)
        begin
            if (end_of_input)
            begin
                push       = 1'b1;
                mode_next  = M_IDLE;
                count_next = '0;
                if (mode_reg == M_IDLE || mode_reg > M_CSTAR)
                begin
                    ent.r0.kind = qwt_pkg::KIND_EOI;
                end
                else if (mode_reg == M_WORD)
                begin
                    ent.r0.kind = qwt_pkg::KIND_EOW;
                    ent.r0.len  = len_cur;
                end
                else
                begin
                    ent.r0.kind = qwt_pkg::KIND_ERR;
                    ent.r0.len  = len_cur;
                end
            end
            else
            begin
                unique case (mode_reg)
                    M_STR, M_WORD:
                    begin
                        push = 1'b1;
                        if ((mode_reg == M_STR && in_byte == qwt_pkg::CH_QUOTE)
                            || (mode_reg == M_WORD && is_delim))
                        begin
                            ent.r0.kind = qwt_pkg::KIND_EOW;
                            ent.r0.len  = len_cur;
                            mode_next   = M_IDLE;
                            count_next  = '0;
                        end
                        else if ((mode_reg == M_WORD && in_byte == qwt_pkg::CH_QUOTE)
                                 || count_full)
                        begin
                            ent.r0.kind = qwt_pkg::KIND_ERR;
                            ent.r0.len  = len_cur;
                            mode_next   = M_IDLE;
                            count_next  = '0;
                        end
                        else
                        begin
                            ent.r0.kind = qwt_pkg::KIND_CHAR;
                            ent.r0.ch   = in_byte;
                            ent.r0.len  = len_inc;
                            count_next  = count_inc;
                        end
                    end
                    M_CMT:
                    begin
                        if (in_byte == qwt_pkg::CH_STAR)
                            mode_next = M_CSTAR;
                    end
                    M_CSTAR:
                    begin
                        if (in_byte == qwt_pkg::CH_SLASH)
                        begin
                            mode_next  = M_IDLE;
                            count_next = '0;
                        end
                        else if (in_byte != qwt_pkg::CH_STAR)
                        begin
                            mode_next = M_CMT;
                        end
                    end
                    M_SLASH:
                    begin
                        if (in_byte == qwt_pkg::CH_STAR)
                        begin
                            mode_next = M_CMT;
                        end
                        else
                        begin
                            // Held slash goes out as a char, then this byte or an error.
                            push        = 1'b1;
                            ent.two     = 1'b1;
                            ent.r0.kind = qwt_pkg::KIND_CHAR;
                            ent.r0.ch   = qwt_pkg::CH_SLASH;
                            ent.r0.len  = LW'(1);
                            if (one_full)
                            begin
                                ent.r1.kind = qwt_pkg::KIND_ERR;
                                ent.r1.len  = LW'(1);
                                mode_next   = M_IDLE;
                                count_next  = '0;
                            end
                            else
                            begin
                                ent.r1.kind = qwt_pkg::KIND_CHAR;
                                ent.r1.ch   = in_byte;
                                ent.r1.len  = LW'(2);
                                mode_next   = M_WORD;
                                count_next  = COUNT_TWO;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = M_IDLE;
                        if (is_delim)
                        begin
                            mode_next = M_IDLE;
                        end
                        else if (in_byte == qwt_pkg::CH_QUOTE)
                        begin
                            mode_next = M_STR;
                        end
                        else if (in_byte == qwt_pkg::CH_SLASH)
                        begin
                            mode_next = M_SLASH;
                        end
                        else
                        begin
                            push = 1'b1;
                            if (count_full)
                            begin
                                ent.r0.kind = qwt_pkg::KIND_ERR;
                                ent.r0.len  = len_cur;
                                count_next  = '0;
                            end
                            else
                            begin
                                ent.r0.kind = qwt_pkg::KIND_CHAR;
                                ent.r0.ch   = in_byte;
                                ent.r0.len  = len_inc;
                                count_next  = count_inc;
                                mode_next   = M_WORD;
                            end
                        end
                    end
                endcase
            end
        end
        ent.r0.last = !ent.two;
        ent.r1.last = 1'b1;
    end

    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_IDLE || mode_reg == M_CMT || mode_reg == M_CSTAR
         || mode_reg == M_SLASH) |-> (count_reg == '0))
        else $error("scanner count not zero outside a word");

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("entry pushed into a full queue");

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("word count passed the limit");

endmodule

/* src/qwt_fifo.sv */
// Two-entry queue of result entries between the scanner and the output stage.
module qwt_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qwt_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output qwt_pkg::entry_t head
);

    qwt_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("entry popped from an empty queue");

    count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

/* src/qwt_back.sv */
// Back end: unpacks queue entries into output beats through an output register.
module qwt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  qwt_pkg::entry_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output qwt_pkg::result_t  result
);

    logic             out_valid_reg, out_valid_next;
    logic             sub_reg, sub_next;
    qwt_pkg::result_t res_reg, res_next;
    logic             load;

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sub_next       = sub_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                res_next = sub_reg ? head.r1 : head.r0;
                // The first half of a paired entry leaves the entry in place.
                if (head.two && !sub_reg)
                begin
                    sub_next = 1'b1;
                end
                else
                begin
                    sub_next = 1'b0;
                    pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    sub_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (!q_empty && head.two))
        else $error("second half pending without a paired entry");

    sub_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sub_reg) |-> (out_valid_reg && !res_reg.last))
        else $error("second half pending but first half marked last");

    pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> res_next.last)
        else $error("entry retired before its last result");

endmodule

/* src/quoted_word_tokenizer.sv */
// Top level of the quoted word tokenizer: scanner, result queue and output stage.
//
//   channel | signals                          | direction | beat
//   --------+----------------------------------+-----------+-----------------------------
//   input   | in_valid in_ready                | in        | in_byte, end_of_input
//   output  | out_valid out_ready              | out       | kind, out_char, word_length, last
//
// One input beat is taken per cycle while the queue is not full; the scanner state updates in that cycle.
// A beat yields zero, one or two results; results leave at one per cycle from the
// output register while out_ready is high, passing first through the queue.
// Reset clears the scanner to idle with a zero count and empties the queue.
// A stalled output fills the two-entry queue, and only then is in_ready dropped;
// a slash pair holds the queue head until its second result has been loaded.
module quoted_word_tokenizer #(
    parameter int MAX_WORD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_char,
    output logic [10:0] word_length,
    output logic        last
);

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    qwt_pkg::entry_t  push_entry;
    qwt_pkg::entry_t  head;
    qwt_pkg::result_t result;

    qwt_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    qwt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    qwt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign kind        = result.kind;
    assign out_char    = result.ch;
    assign word_length = result.len;
    assign last        = result.last;

endmodule

/* tb/qwt_checker.sv */
// Checker for the quoted word tokenizer: predicts the result beats and compares them.
module qwt_checker #(
    parameter int MAX_WORD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  out_char,
    input  logic [10:0] word_length,
    input  logic        last,
    output int          fail_count,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_STRING,
        SCAN_WORD,
        SCAN_COMMENT,
        SCAN_SLASH,
        SCAN_COMMENT_STAR
    } scan_mode_t;

    scan_mode_t       scan_mode;
    int               char_count;
    qwt_pkg::result_t expected_results[$];
    qwt_pkg::result_t want;
    int               failures = 0;

    function automatic void push_result(input logic [1:0] k, input logic [7:0] c);
        qwt_pkg::result_t r;
        r.kind = k;
        r.ch   = c;
        r.len  = qwt_pkg::LEN_W'(char_count);
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void go_idle();
        scan_mode  = SCAN_IDLE;
        char_count = 0;
    endfunction

    // A character that would bring the word to MAX_WORD turns into a format error.
    function automatic bit append_char(input logic [7:0] c);
        if (char_count + 1 >= MAX_WORD)
        begin
            push_result(qwt_pkg::KIND_ERR, 8'h00);
            go_idle();
            return 1'b0;
        end
        char_count++;
        push_result(qwt_pkg::KIND_CHAR, c);
        return 1'b1;
    endfunction

    function automatic void close_word(input logic [1:0] k);
        push_result(k, 8'h00);
        go_idle();
    endfunction

    function automatic void tokenize_beat(input logic [7:0] b, input logic eoi);
        int   first;
        logic is_delim;
        first    = expected_results.size();
        is_delim = (b == qwt_pkg::CH_SPACE) || (b == qwt_pkg::CH_TAB)
                || (b == qwt_pkg::CH_NL) || (b == qwt_pkg::CH_COMMA);
        if (eoi)
        begin
            case (scan_mode)
                SCAN_IDLE: close_word(qwt_pkg::KIND_EOI);
                SCAN_WORD: close_word(qwt_pkg::KIND_EOW);
                default:   close_word(qwt_pkg::KIND_ERR);
            endcase
        end
        else
        begin
            case (scan_mode)
                SCAN_STRING:
                    if (b == qwt_pkg::CH_QUOTE)
                        close_word(qwt_pkg::KIND_EOW);
                    else
                        void'(append_char(b));
                SCAN_WORD:
                    if (is_delim)
                        close_word(qwt_pkg::KIND_EOW);
                    else if (b == qwt_pkg::CH_QUOTE)
                        close_word(qwt_pkg::KIND_ERR);
                    else
                        void'(append_char(b));
                SCAN_COMMENT:
                    if (b == qwt_pkg::CH_STAR)
                        scan_mode = SCAN_COMMENT_STAR;
                SCAN_COMMENT_STAR:
                    if (b == qwt_pkg::CH_SLASH)
                        go_idle();
                    else if (b != qwt_pkg::CH_STAR)
                        scan_mode = SCAN_COMMENT;
                SCAN_SLASH:
                    if (b == qwt_pkg::CH_STAR)
                        scan_mode = SCAN_COMMENT;
                    else
                    begin
                        // The held slash starts a bare word; this byte joins it or is an error.
                        scan_mode = SCAN_WORD;
                        if (append_char(qwt_pkg::CH_SLASH))
                            void'(append_char(b));
                    end
                default:
                    if (is_delim)
                        scan_mode = SCAN_IDLE;
                    else if (b == qwt_pkg::CH_QUOTE)
                        scan_mode = SCAN_STRING;
                    else if (b == qwt_pkg::CH_SLASH)
                        scan_mode = SCAN_SLASH;
                    else
                    begin
                        scan_mode = SCAN_WORD;
                        void'(append_char(b));
                    end
            endcase
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [10:0] exp_val,
                               input logic [10:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_idle();
            expected_results.delete();
            results_owed <= 0;
            fail_count   <= failures;
        end
        else
        begin
            // Predictions go in first; a result never leaves in the cycle of its input.
            if (in_valid && in_ready)
                tokenize_beat(in_byte, end_of_input);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d, char %0d, length %0d",
                           kind, out_char, word_length);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 11'(want.kind), 11'(kind));
                    check_field("out_char", 11'(want.ch), 11'(out_char));
                    check_field("word_length", want.len, word_length);
                    check_field("last", 11'(want.last), 11'(last));
                end
            end
            results_owed <= expected_results.size();
            fail_count   <= failures;
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for the quoted word tokenizer: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte      = 8'h00;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [10:0] word_length;
    logic        last;

    int fail_count;
    int results_owed;
    int sender_idle_pct = 0;
    int rx_idle_pct     = 0;
    int beats_sent      = 0;

    quoted_word_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_char     (out_char),
        .word_length  (word_length),
        .last         (last)
    );

    qwt_checker token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_char     (out_char),
        .word_length  (word_length),
        .last         (last),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic logic is_delim(input logic [7:0] b);
        return (b == qwt_pkg::CH_SPACE) || (b == qwt_pkg::CH_TAB)
            || (b == qwt_pkg::CH_NL) || (b == qwt_pkg::CH_COMMA);
    endfunction

    function automatic logic [7:0] random_delim();
        case ($urandom_range(3))
            0:       return qwt_pkg::CH_SPACE;
            1:       return qwt_pkg::CH_TAB;
            2:       return qwt_pkg::CH_NL;
            default: return qwt_pkg::CH_COMMA;
        endcase
    endfunction

    function automatic logic [7:0] random_word_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_delim(b) || b == qwt_pkg::CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] random_string_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == qwt_pkg::CH_QUOTE);
        return b;
    endfunction

    // Valid stays high across back-to-back beats; here it only drops while the sender idles.
    task automatic send_beat(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_eoi();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_long_word(input int n, input logic quoted);
        logic [7:0] b;
        if (quoted)
            send_beat(qwt_pkg::CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            if (quoted)
                b = random_string_char();
            else
                do
                    b = random_word_char();
                while (i == 0 && b == qwt_pkg::CH_SLASH);
            send_beat(b, 1'b0);
        end
        send_beat(quoted ? qwt_pkg::CH_QUOTE : random_delim(), 1'b0);
    endtask

    task automatic send_random_token();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // Bare word; a leading slash is covered by its own token below.
            do
                b = random_word_char();
            while (b == qwt_pkg::CH_SLASH);
            send_beat(b, 1'b0);
            repeat ($urandom_range(0, 7)) send_beat(random_word_char(), 1'b0);
            if ($urandom_range(9) == 0)
                send_eoi();
            else
                send_beat(random_delim(), 1'b0);
        end
        else if (pick < 50)
        begin
            send_beat(qwt_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) send_beat(random_string_char(), 1'b0);
            if ($urandom_range(19) == 0)
                send_eoi();
            else
                send_beat(qwt_pkg::CH_QUOTE, 1'b0);
        end
        else if (pick < 62)
        begin
            send_text("/*");
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(3))
                    0:       b = qwt_pkg::CH_STAR;
                    1:       b = qwt_pkg::CH_SLASH;
                    default: b = 8'($urandom_range(255));
                endcase
                send_beat(b, 1'b0);
            end
            if ($urandom_range(19) == 0)
                send_eoi();
            else
                send_text("*/");
        end
        else if (pick < 72)
        begin
            repeat ($urandom_range(1, 3)) send_beat(random_delim(), 1'b0);
        end
        else if (pick < 76)
        begin
            send_eoi();
        end
        else if (pick < 86)
        begin
            send_beat(qwt_pkg::CH_SLASH, 1'b0);
            if ($urandom_range(9) == 0)
                send_eoi();
            else
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == qwt_pkg::CH_STAR);
                send_beat(b, 1'b0);
                repeat ($urandom_range(0, 3)) send_beat(random_word_char(), 1'b0);
                send_beat(random_delim(), 1'b0);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(7) == 0)
                    send_eoi();
                else
                    send_beat(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        int target;
        sender_idle_pct = tx_pct;
        rx_idle_pct     = rx_pct;
        target          = beats_sent + count;
        while (beats_sent < target)
        begin
            send_random_token();
            if ($urandom_range(49) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_eoi();
        send_text("\"\"");
        send_text("\"\t,\"");
        send_text("/\"");
        send_eoi();
        send_text("*");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("\n");
        send_text("x\"");
        send_text("/**a**/");
        send_text("\"q");
        send_eoi();
        send_text("/*");
        send_eoi();
        send_text("/");
        send_eoi();
        send_text("/ ,");
        wait_for_drain();

        run_phase(13, 75, 300);
        run_phase(75, 13, 300);

        // Word limit: every character up to the limit, then one that runs into it.
        sender_idle_pct = 0;
        rx_idle_pct     = 0;
        send_long_word(1024, 1'b0);
        run_phase(0, 0, 300);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("PASS quoted_word_tokenizer");
        else
            $display("FAIL quoted_word_tokenizer");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL quoted_word_tokenizer");
        $finish;
    end

endmodule
